### rtl/tcp_rtt_segment_matcher_macros.svh
// assertion macros for the rtt segment matcher checker
// expects clk and rst_n in the scope of each use
`ifndef TCP_RTT_SEGMENT_MATCHER_MACROS_SVH
`define TCP_RTT_SEGMENT_MATCHER_MACROS_SVH

// same-cycle implication
`define TRM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trm check failed");

// next-cycle implication
`define TRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trm check failed");

`endif

### rtl/trm_pkg.sv
// shared types and constants for the tcp rtt segment matcher
// used by trm_datapath, trm_ctrl and the top level
package trm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] len;
        logic [63:0] ts;
    } entry_t;

    typedef enum logic [2:0] {
        CLS_SYNACK = 3'd0,
        CLS_SYN    = 3'd1,
        CLS_FIN    = 3'd2,
        CLS_ACK    = 3'd3,
        CLS_DATA   = 3'd4
    } pkt_class_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_READ = 5'b00100,
        S_CMP  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic walk_rd;
        logic walk_step;
        logic walk_fin;
        logic emit;
    } cmd_t;

    typedef struct packed {
        pkt_class_t cls;
        logic       walk_empty;
        logic       walk_last;
        logic       walk_eq;
        logic       res_hit;
        logic       out_free;
    } status_t;

endpackage

### rtl/trm_datapath.sv
// datapath of the rtt segment matcher: request latch, segment queues, timers, result register
// depends on trm_pkg; driven by trm_ctrl commands
module trm_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  trm_pkg::cmd_t     cmd,
    output trm_pkg::status_t  status,
    input  logic              direction,
    input  logic              syn_flag,
    input  logic              ack_flag,
    input  logic              fin_flag,
    input  logic [31:0]       seq_num,
    input  logic [31:0]       ack_num,
    input  logic [15:0]       payload_size,
    input  logic [63:0]       timestamp,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [63:0]       rtt,
    output logic [63:0]       event_time,
    output logic              report_direction
);

    // latched request
    logic        dir_reg;
    logic        syn_reg;
    logic        ack_reg;
    logic        fin_reg;
    logic [31:0] seq_reg;
    logic [31:0] ackn_reg;
    logic [15:0] size_reg;
    logic [63:0] ts_reg;
    logic [31:0] rel_seq_reg;
    logic [31:0] rel_ack_reg;

    // queues: index 0 downstream, 1 upstream
    trm_pkg::entry_t          q_mem [2][trm_pkg::QUEUE_DEPTH];
    trm_pkg::entry_t          rd_entry_reg;
    logic [trm_pkg::PTR_W-1:0] head_reg [2];
    logic [trm_pkg::PTR_W-1:0] head_next [2];
    logic [trm_pkg::CNT_W-1:0] count_reg [2];
    logic [trm_pkg::CNT_W-1:0] count_next [2];

    logic [31:0] init_seq_reg [2];
    logic [31:0] init_seq_next [2];
    logic [63:0] syn_time_reg, syn_time_next;
    logic [31:0] fin_exp_reg, fin_exp_next;
    logic [63:0] fin_time_reg, fin_time_next;
    logic        res_hit_reg, res_hit_next;
    logic [63:0] res_rtt_reg, res_rtt_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] rtt_reg;
    logic [63:0] event_time_reg;
    logic        report_dir_reg;

    trm_pkg::pkt_class_t        cls;
    logic                       wq;
    logic                       push_en;
    trm_pkg::entry_t            push_entry;
    logic [trm_pkg::SUM_W-1:0]  push_sum;
    logic [trm_pkg::PTR_W-1:0]  push_slot;
    logic [31:0]                walk_target;

    // classification in priority order
    always_comb
    begin
        if (syn_reg && ack_reg)
            cls = trm_pkg::CLS_SYNACK;
        else if (syn_reg)
            cls = trm_pkg::CLS_SYN;
        else if (fin_reg)
            cls = trm_pkg::CLS_FIN;
        else if (ack_reg && (size_reg == 16'd0))
            cls = trm_pkg::CLS_ACK;
        else
            cls = trm_pkg::CLS_DATA;
    end

    assign wq = ~dir_reg;
    assign walk_target = rd_entry_reg.seq + {16'd0, rd_entry_reg.len};

    always_comb
    begin
        push_sum = trm_pkg::SUM_W'(head_reg[dir_reg]) + trm_pkg::SUM_W'(count_reg[dir_reg]);
        if (push_sum >= trm_pkg::SUM_W'(trm_pkg::QUEUE_DEPTH))
            push_slot = trm_pkg::PTR_W'(push_sum - trm_pkg::SUM_W'(trm_pkg::QUEUE_DEPTH));
        else
            push_slot = trm_pkg::PTR_W'(push_sum);
    end

    always_comb
    begin
        push_entry.ts = ts_reg;
        if (cls == trm_pkg::CLS_SYNACK)
        begin
            push_entry.seq = 32'd1;
            push_entry.len = 16'd0;
        end
        else
        begin
            push_entry.seq = rel_seq_reg;
            push_entry.len = size_reg;
        end
    end

    assign push_en = cmd.exec
                   && ((cls == trm_pkg::CLS_SYNACK) || (cls == trm_pkg::CLS_DATA))
                   && (count_reg[dir_reg] != trm_pkg::CNT_W'(trm_pkg::QUEUE_DEPTH));

    always_comb
    begin
        head_next[0]     = head_reg[0];
        head_next[1]     = head_reg[1];
        count_next[0]    = count_reg[0];
        count_next[1]    = count_reg[1];
        init_seq_next[0] = init_seq_reg[0];
        init_seq_next[1] = init_seq_reg[1];
        syn_time_next    = syn_time_reg;
        fin_exp_next     = fin_exp_reg;
        fin_time_next    = fin_time_reg;
        res_hit_next     = res_hit_reg;
        res_rtt_next     = res_rtt_reg;

        if (cmd.exec)
        begin
            res_hit_next = 1'b0;
            case (cls)
                trm_pkg::CLS_SYNACK:
                begin
                    init_seq_next[dir_reg] = seq_reg;
                    res_hit_next = 1'b1;
                    res_rtt_next = ts_reg - syn_time_reg;
                end
                trm_pkg::CLS_SYN:
                begin
                    init_seq_next[dir_reg] = seq_reg;
                    syn_time_next = ts_reg;
                end
                trm_pkg::CLS_FIN:
                begin
                    if (fin_exp_reg == ackn_reg)
                    begin
                        res_hit_next = 1'b1;
                        res_rtt_next = ts_reg - fin_time_reg;
                    end
                    else
                    begin
                        fin_time_next = ts_reg;
                        fin_exp_next  = seq_reg + 32'd1;
                    end
                end
                default:
                begin
                end
            endcase
            if (push_en)
                count_next[dir_reg] = count_reg[dir_reg] + trm_pkg::CNT_W'(1);
        end

        if (cmd.walk_step)
        begin
            if (head_reg[wq] == trm_pkg::PTR_W'(trm_pkg::QUEUE_DEPTH - 1))
                head_next[wq] = '0;
            else
                head_next[wq] = head_reg[wq] + trm_pkg::PTR_W'(1);
            count_next[wq] = count_reg[wq] - trm_pkg::CNT_W'(1);
        end

        if (cmd.walk_fin)
        begin
            res_hit_next = (walk_target == rel_ack_reg);
            res_rtt_next = ts_reg - rd_entry_reg.ts;
            if (count_reg[wq] == trm_pkg::CNT_W'(1))
            begin
                count_next[wq] = '0;
                head_next[wq]  = '0;
            end
        end
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg[0]     <= '0;
            head_reg[1]     <= '0;
            count_reg[0]    <= '0;
            count_reg[1]    <= '0;
            init_seq_reg[0] <= '0;
            init_seq_reg[1] <= '0;
            syn_time_reg    <= '0;
            fin_exp_reg     <= '0;
            fin_time_reg    <= '0;
            res_hit_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            head_reg[0]     <= head_next[0];
            head_reg[1]     <= head_next[1];
            count_reg[0]    <= count_next[0];
            count_reg[1]    <= count_next[1];
            init_seq_reg[0] <= init_seq_next[0];
            init_seq_reg[1] <= init_seq_next[1];
            syn_time_reg    <= syn_time_next;
            fin_exp_reg     <= fin_exp_next;
            fin_time_reg    <= fin_time_next;
            res_hit_reg     <= res_hit_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_rtt_reg <= res_rtt_next;
        if (cmd.load)
        begin
            dir_reg     <= direction;
            syn_reg     <= syn_flag;
            ack_reg     <= ack_flag;
            fin_reg     <= fin_flag;
            seq_reg     <= seq_num;
            ackn_reg    <= ack_num;
            size_reg    <= payload_size;
            ts_reg      <= timestamp;
            rel_seq_reg <= seq_num - init_seq_reg[direction];
            rel_ack_reg <= ack_num - init_seq_reg[~direction];
        end
        if (cmd.emit)
        begin
            rtt_reg        <= res_rtt_reg;
            event_time_reg <= ts_reg;
            report_dir_reg <= dir_reg;
        end
    end

    // segment queue memory
    always_ff @(posedge clk)
    begin
        if (push_en)
            q_mem[dir_reg][push_slot] <= push_entry;
        if (cmd.walk_rd)
            rd_entry_reg <= q_mem[wq][head_reg[wq]];
    end

    assign status.cls        = cls;
    assign status.walk_empty = (count_reg[wq] == '0);
    assign status.walk_last  = (count_reg[wq] == trm_pkg::CNT_W'(1));
    assign status.walk_eq    = (walk_target == rel_ack_reg);
    assign status.res_hit    = res_hit_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid        = out_valid_reg;
    assign rtt              = rtt_reg;
    assign event_time       = event_time_reg;
    assign report_direction = report_dir_reg;

endmodule

### rtl/trm_ctrl.sv
// controller state machine of the rtt segment matcher
// depends on trm_pkg; sequences trm_datapath through commands
module trm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  trm_pkg::status_t  status,
    output trm_pkg::cmd_t     cmd
);

    trm_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            trm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = trm_pkg::S_EXEC;
                end
            end
            trm_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
                if ((status.cls == trm_pkg::CLS_ACK) && !status.walk_empty)
                    state_next = trm_pkg::S_READ;
                else
                    state_next = trm_pkg::S_EMIT;
            end
            trm_pkg::S_READ:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = trm_pkg::S_CMP;
            end
            trm_pkg::S_CMP:
            begin
                // drop head entries until a match or the last one
                if (!status.walk_eq && !status.walk_last)
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = trm_pkg::S_READ;
                end
                else
                begin
                    cmd.walk_fin = 1'b1;
                    state_next   = trm_pkg::S_EMIT;
                end
            end
            trm_pkg::S_EMIT:
            begin
                if (!status.res_hit)
                    state_next = trm_pkg::S_IDLE;
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = trm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = trm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= trm_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != trm_pkg::S_IDLE);

endmodule

### rtl/tcp_rtt_segment_matcher.sv
// syn, syn-ack, fin and data requests pass through load, exec and emit; only a syn-ack or a matched fin gives a result
// pure ack: a read and a compare step per queue entry examined (1..QUEUE_DEPTH), one memory read each; no walk if empty
// a new request is taken only in idle: in_stall is high until the last request is done, or its hit has been emitted
// the result register lets the next request in while a result waits downstream
// reset: asynchronous active low, clears queue pointers, timers and valid state
module tcp_rtt_segment_matcher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        direction,
    input  logic        syn_flag,
    input  logic        ack_flag,
    input  logic        fin_flag,
    input  logic [31:0] seq_num,
    input  logic [31:0] ack_num,
    input  logic [15:0] payload_size,
    input  logic [63:0] timestamp,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] rtt,
    output logic [63:0] event_time,
    output logic        report_direction
);

    trm_pkg::cmd_t    cmd;
    trm_pkg::status_t status;

    trm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    trm_datapath u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .direction        (direction),
        .syn_flag         (syn_flag),
        .ack_flag         (ack_flag),
        .fin_flag         (fin_flag),
        .seq_num          (seq_num),
        .ack_num          (ack_num),
        .payload_size     (payload_size),
        .timestamp        (timestamp),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .rtt              (rtt),
        .event_time       (event_time),
        .report_direction (report_direction)
    );

endmodule

### rtl/trm_checker.sv
// port-level checks for the rtt segment matcher
// depends on tcp_rtt_segment_matcher_macros.svh; bound to the top level
`include "tcp_rtt_segment_matcher_macros.svh"

module trm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        direction,
    input logic        syn_flag,
    input logic        ack_flag,
    input logic        fin_flag,
    input logic [31:0] seq_num,
    input logic [31:0] ack_num,
    input logic [15:0] payload_size,
    input logic [63:0] timestamp,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] rtt,
    input logic [63:0] event_time,
    input logic        report_direction
);

    // a result stays while stalled
    `TRM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `TRM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(rtt) && $stable(event_time))
    // one request at a time
    `TRM_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
    // a new result only comes out of a request in progress
    `TRM_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind tcp_rtt_segment_matcher trm_checker u_trm_checker (.*);
